>>> design/srms_pkg.sv
// srms_pkg: shared types, register indexes and the ramp delay table
// for the stepper ramp move sequencer; no dependencies
`timescale 1ns / 1ps

package srms_pkg;

	localparam int RAMP_STEPS_DEF = 25;
	localparam int MAX_UNITS_DEF  = 7;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	localparam logic [CFG_IDX_W-1:0] CFG_IDX_CRUISE_MS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_STEPS     = 2'd1;

	localparam logic [5:0] CRUISE_MS_RST = 6'd4;
	localparam logic [7:0] STEPS_RST     = 8'd50;

	typedef enum logic [1:0] {
		SEG_IDLE   = 2'd0,
		SEG_UP     = 2'd1,
		SEG_CRUISE = 2'd2,
		SEG_DOWN   = 2'd3
	} seg_t;

	typedef struct packed {
		seg_t        seg;
		logic [4:0]  ramp_index;
		logic [10:0] cruise_left;
		logic [1:0]  coil_phase;
		logic [5:0]  phase_timer;
		logic        reverse_dir;
	} motion_t;

	typedef struct packed {
		logic coil_a_pos;
		logic coil_a_neg;
		logic coil_b_pos;
		logic coil_b_neg;
		logic enable_a;
		logic enable_b;
		logic busy_res;
		logic move_done;
	} result_t;

	// ms per coil phase for each ramp step, 4 beyond the listed steps
	function automatic logic [5:0] ramp_delay(input logic [4:0] idx);
		logic [5:0] d;
		case (idx)
			5'd0:  d = 6'd45;
			5'd1:  d = 6'd38;
			5'd2:  d = 6'd32;
			5'd3:  d = 6'd27;
			5'd4:  d = 6'd23;
			5'd5:  d = 6'd20;
			5'd6:  d = 6'd17;
			5'd7:  d = 6'd15;
			5'd8:  d = 6'd13;
			5'd9:  d = 6'd11;
			5'd10: d = 6'd10;
			5'd11: d = 6'd9;
			5'd12: d = 6'd8;
			5'd13: d = 6'd7;
			5'd14: d = 6'd7;
			5'd15: d = 6'd6;
			5'd16: d = 6'd6;
			5'd17: d = 6'd6;
			5'd18: d = 6'd5;
			5'd19: d = 6'd5;
			5'd20: d = 6'd5;
			5'd21: d = 6'd5;
			5'd22: d = 6'd5;
			5'd23: d = 6'd5;
			default: d = 6'd4;
		endcase
		return d;
	endfunction

	// drive pattern per phase: p1, n1, p2, n2
	function automatic logic [3:0] phase_bits(input logic [1:0] ph);
		logic [3:0] b;
		case (ph)
			2'd0: b = 4'b1010;
			2'd1: b = 4'b1001;
			2'd2: b = 4'b0101;
			default: b = 4'b0110;
		endcase
		return b;
	endfunction

endpackage

>>> design/srms_step.sv
// srms_step: next motion state and result for one item
// depends on srms_pkg
`timescale 1ns / 1ps

module srms_step #(
	parameter int RAMP_STEPS = srms_pkg::RAMP_STEPS_DEF,
	parameter int MAX_UNITS  = srms_pkg::MAX_UNITS_DEF
) (
	input  srms_pkg::motion_t       cur,
	input  logic                    mode,
	input  logic signed [3:0]       move_units,
	input  logic [5:0]              cruise_phase_ms,
	input  logic [7:0]              steps_per_unit,
	output srms_pkg::motion_t       nxt,
	output srms_pkg::result_t       res
);

	localparam logic [4:0] RAMP_LAST = 5'(RAMP_STEPS - 1);
	localparam logic [3:0] UNITS_MAX = 4'(MAX_UNITS);

	logic [3:0]  mag;
	logic        cmd_ok;
	logic [4:0]  ramp_i;
	logic [5:0]  delay;
	logic [6:0]  timer_inc;
	logic        done;
	logic [3:0]  bits;

	assign mag    = move_units[3] ? 4'(-move_units) : 4'(move_units);
	assign cmd_ok = (cur.seg == srms_pkg::SEG_IDLE) && (mag != 4'd0) && (mag <= UNITS_MAX);
	assign ramp_i = (cur.ramp_index > RAMP_LAST) ? RAMP_LAST : cur.ramp_index;

	always_comb begin
		case (cur.seg)
			srms_pkg::SEG_UP:   delay = srms_pkg::ramp_delay(ramp_i);
			srms_pkg::SEG_DOWN: delay = srms_pkg::ramp_delay(RAMP_LAST - ramp_i);
			default:            delay = (cruise_phase_ms == 6'd0) ? 6'd1 : cruise_phase_ms;
		endcase
	end

	assign timer_inc = {1'b0, cur.phase_timer} + 7'd1;

	// next state
	always_comb begin
		nxt  = cur;
		done = 1'b0;
		if (mode) begin
			if (cmd_ok) begin
				nxt.reverse_dir = move_units[3];
				nxt.cruise_left = 11'(mag - 4'd1) * 11'(steps_per_unit);
				nxt.seg         = srms_pkg::SEG_UP;
				nxt.ramp_index  = 5'd0;
				nxt.coil_phase  = 2'd0;
				nxt.phase_timer = 6'd0;
			end
		end else if (cur.seg != srms_pkg::SEG_IDLE) begin
			if (timer_inc >= {1'b0, delay}) begin
				nxt.phase_timer = 6'd0;
				if (cur.coil_phase == 2'd3) begin
					nxt.coil_phase = 2'd0;
					// full step finished
					case (cur.seg)
						srms_pkg::SEG_UP: begin
							if (cur.ramp_index >= RAMP_LAST) begin
								nxt.ramp_index = 5'd0;
								nxt.seg = (cur.cruise_left != 11'd0) ? srms_pkg::SEG_CRUISE
								                                     : srms_pkg::SEG_DOWN;
							end else begin
								nxt.ramp_index = cur.ramp_index + 5'd1;
							end
						end
						srms_pkg::SEG_CRUISE: begin
							if (cur.cruise_left <= 11'd1) begin
								nxt.cruise_left = 11'd0;
								nxt.seg         = srms_pkg::SEG_DOWN;
								nxt.ramp_index  = 5'd0;
							end else begin
								nxt.cruise_left = cur.cruise_left - 11'd1;
							end
						end
						default: begin
							if (cur.ramp_index >= RAMP_LAST) begin
								nxt.seg        = srms_pkg::SEG_IDLE;
								nxt.ramp_index = 5'd0;
								done           = 1'b1;
							end else begin
								nxt.ramp_index = cur.ramp_index + 5'd1;
							end
						end
					endcase
				end else begin
					nxt.coil_phase = cur.coil_phase + 2'd1;
				end
			end else begin
				nxt.phase_timer = timer_inc[5:0];
			end
		end
	end

	// result from the state after the item
	assign bits = srms_pkg::phase_bits(nxt.coil_phase);

	always_comb begin
		res = '0;
		if (nxt.seg != srms_pkg::SEG_IDLE) begin
			if (nxt.reverse_dir) begin
				res.coil_a_pos = bits[1];
				res.coil_a_neg = bits[0];
				res.coil_b_pos = bits[3];
				res.coil_b_neg = bits[2];
			end else begin
				res.coil_a_pos = bits[3];
				res.coil_a_neg = bits[2];
				res.coil_b_pos = bits[1];
				res.coil_b_neg = bits[0];
			end
			res.enable_a = 1'b1;
			res.enable_b = 1'b1;
			res.busy_res = 1'b1;
		end
		res.move_done = done;
	end

endmodule

>>> design/stepper_ramp_move_sequencer.sv
// stepper_ramp_move_sequencer: top level with input register, motion state,
// config registers and result register; depends on srms_pkg and srms_step
//
//   channel | signals                                   | handshake
//   in      | mode, move_units                          | in_valid / in_stall
//   out     | coil_*, enable_a/b, busy_res, move_done   | out_valid / out_stall
//   cfg     | cfg_index, cfg_data                       | cfg_valid / cfg_ready
//
// one item per cycle while out_stall does not hold the result register; an item goes from
// the input register through the single state update into the result register
// arst_n clears the motion state, both valid flags and loads the register defaults
// out_stall holds the result register; in_stall rises only while an item waits
// behind a stalled result, so one item is held on each side
`timescale 1ns / 1ps

module stepper_ramp_move_sequencer #(
	parameter int RAMP_STEPS = srms_pkg::RAMP_STEPS_DEF,
	parameter int MAX_UNITS  = srms_pkg::MAX_UNITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            mode,
	input  logic signed [3:0]               move_units,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            coil_a_pos,
	output logic                            coil_a_neg,
	output logic                            coil_b_pos,
	output logic                            coil_b_neg,
	output logic                            enable_a,
	output logic                            enable_b,
	output logic                            busy_res,
	output logic                            move_done,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [srms_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [srms_pkg::CFG_DATA_W-1:0] cfg_data
);

	logic                valid_s1;
	logic                mode_s1;
	logic signed [3:0]   move_units_s1;
	logic                out_valid_q;
	srms_pkg::result_t   res_q;
	srms_pkg::motion_t   motion_q;
	srms_pkg::motion_t   motion_nxt;
	srms_pkg::result_t   res_nxt;
	logic [5:0]          cruise_phase_ms_q;
	logic [7:0]          steps_per_unit_q;
	logic                advance;

	assign advance   = valid_s1 && !(out_valid_q && out_stall);
	assign in_stall  = valid_s1 && !advance;
	assign cfg_ready = 1'b1;

	srms_step #(
		.RAMP_STEPS (RAMP_STEPS),
		.MAX_UNITS  (MAX_UNITS)
	) u_step (
		.cur             (motion_q),
		.mode            (mode_s1),
		.move_units      (move_units_s1),
		.cruise_phase_ms (cruise_phase_ms_q),
		.steps_per_unit  (steps_per_unit_q),
		.nxt             (motion_nxt),
		.res             (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			mode_s1       <= mode;
			move_units_s1 <= move_units;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			motion_q <= '{seg: srms_pkg::SEG_IDLE, default: '0};
		end else if (advance) begin
			motion_q <= motion_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cruise_phase_ms_q <= srms_pkg::CRUISE_MS_RST;
			steps_per_unit_q  <= srms_pkg::STEPS_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				srms_pkg::CFG_IDX_CRUISE_MS: cruise_phase_ms_q <= cfg_data[5:0];
				srms_pkg::CFG_IDX_STEPS:     steps_per_unit_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign coil_a_pos = res_q.coil_a_pos;
	assign coil_a_neg = res_q.coil_a_neg;
	assign coil_b_pos = res_q.coil_b_pos;
	assign coil_b_neg = res_q.coil_b_neg;
	assign enable_a   = res_q.enable_a;
	assign enable_b   = res_q.enable_b;
	assign busy_res   = res_q.busy_res;
	assign move_done  = res_q.move_done;

`ifndef SYNTH
	// a finished move never reports busy in the same item
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.move_done |-> !res_q.busy_res)
		else $error("move_done with busy_res high");

	// ramp index stays within the ramp
	a_ramp_range: assert property (@(posedge clk) disable iff (!arst_n)
		motion_q.ramp_index <= 5'(RAMP_STEPS - 1))
		else $error("ramp_index beyond last ramp step");

	// an item leaving the input register always lands in the result register
	a_advance_out: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("advanced item lost");

	// motion state moves only with an item
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(motion_q))
		else $error("motion state changed without an item");

	// idle state carries no leftover step position
	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		motion_q.seg == srms_pkg::SEG_IDLE |-> motion_q.ramp_index == 5'd0)
		else $error("ramp_index nonzero while idle");
`endif

endmodule

>>> dv/tb_top.sv
// tb_top: self-checking testbench for the stepper ramp move sequencer
// drives ticks and move commands, predicts every coil/enable/done result
// depends on srms_pkg and the stepper_ramp_move_sequencer top level
`timescale 1ns / 1ps

module tb_top;

	localparam int LAST_STEP    = srms_pkg::RAMP_STEPS_DEF - 1;
	localparam int ITEM_TARGET  = 1150;
	localparam int HOLD_CYCLES  = 200;
	localparam int WATCHDOG_MAX = 3000;
	localparam int DRAIN_CYCLES = 4;

	// indexes past the register list, writes there must be ignored
	localparam logic [srms_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE0 = 2'd2;
	localparam logic [srms_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE1 = 2'd3;

	localparam logic MODE_TICK = 1'b0;
	localparam logic MODE_MOVE = 1'b1;

	localparam logic [5:0] RAMP_MS [srms_pkg::RAMP_STEPS_DEF] = '{
		6'd45, 6'd38, 6'd32, 6'd27, 6'd23, 6'd20, 6'd17, 6'd15, 6'd13, 6'd11,
		6'd10, 6'd9, 6'd8, 6'd7, 6'd7, 6'd6, 6'd6, 6'd6, 6'd5, 6'd5,
		6'd5, 6'd5, 6'd5, 6'd5, 6'd4
	};
	// p1 n1 p2 n2 per coil phase
	localparam logic [3:0] PHASE_DRV [4] = '{4'b1010, 4'b1001, 4'b0101, 4'b0110};

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            in_valid = 1'b0;
	logic                            in_stall;
	logic                            mode = 1'b0;
	logic signed [3:0]               move_units = 4'sd0;
	logic                            out_valid;
	logic                            out_stall = 1'b0;
	logic                            coil_a_pos, coil_a_neg, coil_b_pos, coil_b_neg;
	logic                            enable_a, enable_b, busy_res, move_done;
	logic                            cfg_valid = 1'b0;
	logic                            cfg_ready;
	logic [srms_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [srms_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	// predicted motion state and register copies
	srms_pkg::seg_t seg_q = srms_pkg::SEG_IDLE;
	logic [4:0]     rix_q = '0;
	logic [10:0]    cruise_q = '0;
	logic [1:0]     ph_q = '0;
	logic [5:0]     tmr_q = '0;
	logic           rev_q = 1'b0;
	logic [5:0]     cms_q = srms_pkg::CRUISE_MS_RST;
	logic [7:0]     spu_q = srms_pkg::STEPS_RST;

	srms_pkg::result_t pending_results[$];
	int      errors = 0;
	int      sent_items = 0;
	int      burst_left = 0;
	bit      no_gaps = 1'b0;
	int      hold_req = 0;
	int      hold_left = 0;
	int      stretch_left = 0;
	int      stall_pct = 0;
	int      quiet_cycles = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	stepper_ramp_move_sequencer i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.mode       (mode),
		.move_units (move_units),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.coil_a_pos (coil_a_pos),
		.coil_a_neg (coil_a_neg),
		.coil_b_pos (coil_b_pos),
		.coil_b_neg (coil_b_neg),
		.enable_a   (enable_a),
		.enable_b   (enable_b),
		.busy_res   (busy_res),
		.move_done  (move_done),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	// ticks that the current coil phase is held
	function automatic int hold_ms();
		int i;
		i = (int'(rix_q) > LAST_STEP) ? LAST_STEP : int'(rix_q);
		case (seg_q)
			srms_pkg::SEG_UP:   return int'(RAMP_MS[i]);
			srms_pkg::SEG_DOWN: return int'(RAMP_MS[LAST_STEP - i]);
			default:            return (cms_q == 6'd0) ? 1 : int'(cms_q);
		endcase
	endfunction

	// one full step done, returns 1 when the move ends
	function automatic logic advance_step();
		case (seg_q)
			srms_pkg::SEG_UP: begin
				if (rix_q >= LAST_STEP) begin
					rix_q = '0;
					seg_q = (cruise_q != '0) ? srms_pkg::SEG_CRUISE : srms_pkg::SEG_DOWN;
				end else begin
					rix_q++;
				end
			end
			srms_pkg::SEG_CRUISE: begin
				if (cruise_q != '0)
					cruise_q--;
				if (cruise_q == '0) begin
					seg_q = srms_pkg::SEG_DOWN;
					rix_q = '0;
				end
			end
			default: begin
				if (rix_q >= LAST_STEP) begin
					seg_q = srms_pkg::SEG_IDLE;
					rix_q = '0;
					return 1'b1;
				end
				rix_q++;
			end
		endcase
		return 1'b0;
	endfunction

	function automatic srms_pkg::result_t next_coil_state(input logic m,
		input logic signed [3:0] u);
		srms_pkg::result_t r;
		logic [3:0]        drv;
		int                mag;
		logic              fin;
		fin = 1'b0;
		if (m == MODE_MOVE) begin
			mag = (u < 0) ? -int'(u) : int'(u);
			if (seg_q == srms_pkg::SEG_IDLE && mag >= 1 && mag <= srms_pkg::MAX_UNITS_DEF) begin
				rev_q = (u < 0);
				cruise_q = 11'((mag - 1) * int'(spu_q));
				seg_q = srms_pkg::SEG_UP;
				rix_q = '0;
				ph_q = '0;
				tmr_q = '0;
			end
		end else if (seg_q != srms_pkg::SEG_IDLE) begin
			if (int'(tmr_q) + 1 >= hold_ms()) begin
				tmr_q = '0;
				if (ph_q == 2'd3) begin
					ph_q = 2'd0;
					fin = advance_step();
				end else begin
					ph_q++;
				end
			end else begin
				tmr_q++;
			end
		end
		r = '0;
		if (seg_q != srms_pkg::SEG_IDLE) begin
			drv = PHASE_DRV[ph_q];
			// negative moves swap the windings
			if (rev_q)
				drv = {drv[1:0], drv[3:2]};
			{r.coil_a_pos, r.coil_a_neg, r.coil_b_pos, r.coil_b_neg} = drv;
			r.enable_a = 1'b1;
			r.enable_b = 1'b1;
			r.busy_res = 1'b1;
		end
		r.move_done = fin;
		return r;
	endfunction

	task automatic send_item(input logic m, input logic signed [3:0] u);
		int gap;
		if (!no_gaps && burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(9) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 4);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		if (burst_left > 0)
			burst_left--;
		in_valid <= 1'b1;
		mode <= m;
		move_units <= u;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pending_results.push_back(next_coil_state(m, u));
		sent_items++;
	endtask

	task automatic write_reg(input logic [srms_pkg::CFG_IDX_W-1:0] idx,
		input logic [srms_pkg::CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			srms_pkg::CFG_IDX_CRUISE_MS: cms_q = data[5:0];
			srms_pkg::CFG_IDX_STEPS: spu_q = data;
			default: ;
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic test_idle_items();
		send_item(MODE_TICK, 4'sd0);
		send_item(MODE_TICK, -4'sd8);
		send_item(MODE_TICK, 4'sd7);
		// zero and -8 never start a move
		send_item(MODE_MOVE, 4'sd0);
		send_item(MODE_MOVE, -4'sd8);
		for (int k = 0; k < 30; k++) begin
			if ($urandom_range(1) == 0)
				send_item(MODE_TICK, 4'($urandom));
			else
				send_item(MODE_MOVE, ($urandom_range(1) == 0) ? 4'sd0 : -4'sd8);
		end
		wait_idle();
	endtask

	task automatic test_cfg_regs();
		write_reg(CFG_IDX_SPARE0, 8'hFF);
		write_reg(CFG_IDX_SPARE1, 8'h00);
		write_reg(srms_pkg::CFG_IDX_CRUISE_MS, 8'hC0);
		write_reg(srms_pkg::CFG_IDX_STEPS, 8'd255);
		write_reg(srms_pkg::CFG_IDX_CRUISE_MS, 8'd63);
		write_reg(srms_pkg::CFG_IDX_STEPS, 8'd0);
		repeat (10) send_item(MODE_TICK, 4'($urandom));
		wait_idle();
		write_reg(srms_pkg::CFG_IDX_CRUISE_MS, 8'h81);
		write_reg(srms_pkg::CFG_IDX_STEPS, 8'($urandom_range(1, 255)));
	endtask

	task automatic test_move_start();
		int                size;
		logic signed [3:0] units;
		size = $urandom_range(1, srms_pkg::MAX_UNITS_DEF);
		units = ($urandom_range(1) == 0) ? 4'(size) : 4'(-size);
		send_item(MODE_MOVE, units);
		// commands while a move runs are dropped
		send_item(MODE_MOVE, -units);
		send_item(MODE_MOVE, 4'sd7);
		send_item(MODE_MOVE, -4'sd8);
		send_item(MODE_MOVE, 4'sd0);
		for (int k = 0; k < 10; k++)
			send_item(MODE_TICK, 4'(k * 5));
	endtask

	task automatic test_backpressure();
		hold_req = HOLD_CYCLES;
		no_gaps = 1'b1;
		repeat (60) send_item(MODE_TICK, 4'($urandom));
		no_gaps = 1'b0;
		wait_idle();
	endtask

	task automatic test_random_items();
		while (sent_items < ITEM_TARGET) begin
			// occasional register write with nothing in flight
			if ($urandom_range(149) == 0) begin
				wait_idle();
				write_reg(2'($urandom), 8'($urandom));
			end
			send_item(($urandom_range(99) < 6) ? MODE_MOVE : MODE_TICK, 4'($urandom));
		end
		wait_idle();
	endtask

	function automatic void cmp_bit(input string name, input logic want, input logic got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s expected %b actual %b", $time, name, want, got);
		end
	endfunction

	always @(posedge clk) begin
		srms_pkg::result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: result with no expected item, expected none actual %b",
					$time, {coil_a_pos, coil_a_neg, coil_b_pos, coil_b_neg,
					enable_a, enable_b, busy_res, move_done});
			end else begin
				want = pending_results.pop_front();
				cmp_bit("coil_a_pos", want.coil_a_pos, coil_a_pos);
				cmp_bit("coil_a_neg", want.coil_a_neg, coil_a_neg);
				cmp_bit("coil_b_pos", want.coil_b_pos, coil_b_pos);
				cmp_bit("coil_b_neg", want.coil_b_neg, coil_b_neg);
				cmp_bit("enable_a", want.enable_a, enable_a);
				cmp_bit("enable_b", want.enable_b, enable_b);
				cmp_bit("busy_res", want.busy_res, busy_res);
				cmp_bit("move_done", want.move_done, move_done);
			end
		end
	end

	// result side stall: random regimes, plus a long hold on request
	always @(posedge clk) begin
		if (hold_req != 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			if (stretch_left == 0) begin
				stretch_left = $urandom_range(16, 128);
				case ($urandom_range(3))
					0: stall_pct = 0;
					1: stall_pct = 15;
					2: stall_pct = 40;
					default: stall_pct = 75;
				endcase
			end
			stretch_left--;
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_MAX) begin
			$display("%0t: no item accepted for %0d cycles", $time, quiet_cycles);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_idle_items();
		test_cfg_regs();
		test_move_start();
		test_backpressure();
		test_random_items();
		wait_idle();
		if (errors == 0 && pending_results.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

>>> filelist.f
design/srms_pkg.sv
design/srms_step.sv
design/stepper_ramp_move_sequencer.sv
dv/tb_top.sv
